### src/sha256_pkg.sv
// Shared types, constants and sigma functions of the SHA-256 core.
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned LEN_SLOT    = 14;
    localparam int unsigned RND_W       = $clog2(ROUNDS);
    localparam int unsigned FILL_W      = $clog2(BLOCK_WORDS);
    localparam int unsigned IDX_W       = $clog2(HASH_WORDS);

    typedef logic [31:0] t_word;

    localparam t_word PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_vars;

    typedef struct packed {
        t_word w0;
        t_word w1;
        t_word w9;
        t_word w14;
    } t_taps;

    localparam t_word [0:HASH_WORDS-1] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word [0:ROUNDS-1] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

### src/sha256_if.sv
// Handshake interfaces for the message word and digest word channels.
`timescale 1ns / 1ps

interface sha256_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

interface sha256_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_last, input ready);
    modport sink (input valid, input digest_word, input digest_index, input digest_last,
                  output ready);
endinterface

### src/sha256_round.sv
// Shared SHA-256 round unit with the message schedule expansion.
`timescale 1ns / 1ps

module sha256_round (
    input  sha256_pkg::t_vars i_vars,
    input  sha256_pkg::t_word i_k,
    input  sha256_pkg::t_taps i_taps,
    output sha256_pkg::t_vars o_vars,
    output sha256_pkg::t_word o_w_next
);
    import sha256_pkg::*;

    t_word s_ch;
    t_word s_maj;
    t_word s_t1;
    t_word s_t2;

    assign s_ch  = (i_vars.e & i_vars.f) ^ (~i_vars.e & i_vars.g);
    assign s_maj = (i_vars.a & i_vars.b) ^ (i_vars.a & i_vars.c) ^ (i_vars.b & i_vars.c);
    assign s_t1  = i_vars.h + big_sig1(i_vars.e) + s_ch + i_k + i_taps.w0;
    assign s_t2  = big_sig0(i_vars.a) + s_maj;

    always_comb begin
        o_vars.h = i_vars.g;
        o_vars.g = i_vars.f;
        o_vars.f = i_vars.e;
        o_vars.e = i_vars.d + s_t1;
        o_vars.d = i_vars.c;
        o_vars.c = i_vars.b;
        o_vars.b = i_vars.a;
        o_vars.a = s_t1 + s_t2;
    end

    assign o_w_next = small_sig1(i_taps.w14) + i_taps.w9 + small_sig0(i_taps.w1) + i_taps.w0;

endmodule

### src/sha256_hash_core.sv
// Top level of the streaming SHA-256 core: buffering, padding, sequencing and digest output.
//
// Channel   Direction  Request contents
// i_msg     in         data_word[31:0], byte_count[2:0], last_word
// o_dig     out        digest_word[31:0], digest_index[2:0], digest_last
//
// A word that does not complete a block is taken and the core stays ready for the next word.
// A completed block runs its 64 rounds in the shared round unit and then the chain
// addition before the next word is taken.
// A last word adds up to 18 padding words, one or two compressions, and then eight
// digest requests, one per cycle when o_dig is ready.
// Synchronous active-low reset loads the initial hash and clears the counters.
`timescale 1ns / 1ps

module sha256_hash_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_msg_if.sink          i_msg,
    sha256_dig_if.source        o_dig
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_RUN,
        S_ADD,
        S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [RND_W-1:0]            r_round, n_round;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic [63:0]                 r_bits, n_bits;
    t_word [0:HASH_WORDS-1]      r_chain, n_chain;
    logic                        r_final, n_final;
    logic                        r_marker, n_marker;
    logic                        r_len_hi, n_len_hi;
    logic                        r_len_done, n_len_done;
    logic [IDX_W-1:0]            r_idx, n_idx;
    t_vars                       r_vars, n_vars;
    t_word [0:BLOCK_WORDS-1]     r_win, n_win;

    logic                        s_push;
    t_word                       s_push_word;
    logic [2:0]                  s_nbytes;
    t_vars                       s_round_vars;
    t_word                       s_w_next;
    t_taps                       s_taps;

    assign s_taps.w0  = r_win[0];
    assign s_taps.w1  = r_win[1];
    assign s_taps.w9  = r_win[9];
    assign s_taps.w14 = r_win[14];

    sha256_round u_round (
        .i_vars   (r_vars),
        .i_k      (ROUND_K[r_round]),
        .i_taps   (s_taps),
        .o_vars   (s_round_vars),
        .o_w_next (s_w_next)
    );

    assign s_nbytes = (!i_msg.last_word || i_msg.byte_count > 3'd4) ? 3'd4 : i_msg.byte_count;

    assign i_msg.ready        = (r_state == S_IDLE);
    assign o_dig.valid        = (r_state == S_OUT);
    assign o_dig.digest_word  = r_chain[r_idx];
    assign o_dig.digest_index = r_idx;
    assign o_dig.digest_last  = (r_idx == IDX_W'(HASH_WORDS - 1));

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_chain    = r_chain;
        n_final    = r_final;
        n_marker   = r_marker;
        n_len_hi   = r_len_hi;
        n_len_done = r_len_done;
        n_idx      = r_idx;
        n_vars     = r_vars;
        n_win      = r_win;
        s_push      = 1'b0;
        s_push_word = '0;

        case (r_state)
            S_IDLE: begin
                if (i_msg.valid) begin
                    s_push = 1'b1;
                    n_bits = r_bits + {58'd0, s_nbytes, 3'd0};
                    if (!i_msg.last_word) begin
                        s_push_word = i_msg.data_word;
                    end else begin
                        n_state    = S_PAD;
                        n_final    = 1'b1;
                        n_len_hi   = 1'b0;
                        n_len_done = 1'b0;
                        n_marker   = 1'b0;
                        case (s_nbytes)
                            3'd0: s_push_word = PAD_WORD;
                            3'd1: s_push_word = {i_msg.data_word[31:24], 8'h80, 16'h0000};
                            3'd2: s_push_word = {i_msg.data_word[31:16], 8'h80, 8'h00};
                            3'd3: s_push_word = {i_msg.data_word[31:8], 8'h80};
                            default: begin
                                s_push_word = i_msg.data_word;
                                n_marker    = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_PAD: begin
                s_push = 1'b1;
                if (r_marker) begin
                    s_push_word = PAD_WORD;
                    n_marker    = 1'b0;
                end else if (r_fill == FILL_W'(LEN_SLOT)) begin
                    s_push_word = r_bits[63:32];
                    n_len_hi    = 1'b1;
                end else if (r_len_hi && r_fill == FILL_W'(LEN_SLOT + 1)) begin
                    s_push_word = r_bits[31:0];
                    n_len_done  = 1'b1;
                end else begin
                    s_push_word = '0;
                end
            end
            S_RUN: begin
                n_vars  = s_round_vars;
                n_win   = {r_win[1:BLOCK_WORDS-1], s_w_next};
                n_round = r_round + RND_W'(1);
                if (r_round == RND_W'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_vars.a;
                n_chain[1] = r_chain[1] + r_vars.b;
                n_chain[2] = r_chain[2] + r_vars.c;
                n_chain[3] = r_chain[3] + r_vars.d;
                n_chain[4] = r_chain[4] + r_vars.e;
                n_chain[5] = r_chain[5] + r_vars.f;
                n_chain[6] = r_chain[6] + r_vars.g;
                n_chain[7] = r_chain[7] + r_vars.h;
                n_idx      = '0;
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_len_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    if (r_idx == IDX_W'(HASH_WORDS - 1)) begin
                        n_state = S_IDLE;
                        n_chain = HASH_IV;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_final = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (s_push) begin
            n_win  = {r_win[1:BLOCK_WORDS-1], s_push_word};
            n_fill = r_fill + FILL_W'(1);
            if (r_fill == FILL_W'(BLOCK_WORDS - 1)) begin
                n_state = S_RUN;
                n_round = '0;
                n_vars  = r_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= '0;
            r_fill     <= '0;
            r_bits     <= '0;
            r_chain    <= HASH_IV;
            r_final    <= 1'b0;
            r_marker   <= 1'b0;
            r_len_hi   <= 1'b0;
            r_len_done <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_fill     <= n_fill;
            r_bits     <= n_bits;
            r_chain    <= n_chain;
            r_final    <= n_final;
            r_marker   <= n_marker;
            r_len_hi   <= n_len_hi;
            r_len_done <= n_len_done;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vars <= n_vars;
        r_win  <= n_win;
    end

`ifndef ASSERT_OFF
    a_last_round_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_round == RND_W'(ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("Final round was not followed by the chain addition.");

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid |-> !i_msg.ready)
        else $error("Message words are taken while a digest is pending.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dig.valid && o_dig.ready && o_dig.digest_last) |=>
        (r_state == S_IDLE && r_fill == '0 && r_bits == 64'd0 && r_chain == HASH_IV))
        else $error("The core did not restart after the final digest word.");

    a_pad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_final && !(r_marker && r_len_done)))
        else $error("Padding sequence is out of order.");
`endif

endmodule

### dv/sha256_hash_core_test.sv
// Self-checking testbench for sha256_hash_core: directed and random messages against a SHA-256 predictor.
`timescale 1ns / 1ps

module sha256_hash_core_test;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned HOLD_TRIGGER = 80;
    localparam int unsigned LEN_SLOT     = 14;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } msg_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_req_t;

    logic i_clk;
    logic i_rst_n;

    sha256_msg_if msg_ch ();
    sha256_dig_if dig_ch ();

    sha256_hash_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch),
        .o_dig   (dig_ch)
    );

    msg_req_t    msg_backlog[$];
    digest_req_t expected_digests[$];
    int unsigned total_items;
    int unsigned accepted_items;
    int unsigned fail_count;
    int unsigned cycle_count;

    logic [31:0] chain_h [8];
    logic [31:0] chunk   [16];
    int unsigned chunk_fill;
    logic [63:0] msg_bits;

    int unsigned send_gap;
    int unsigned send_burst;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_left;
    int unsigned digests_seen;
    bit          long_hold_done;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) begin
            chain_h[i] = SHA_IV[i];
        end
        chunk_fill = 0;
        msg_bits   = '0;
    endtask

    task automatic compress_chunk();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w[t] = chunk[t];
            end else begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = chain_h[i];
        end
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_h[i] = chain_h[i] + v[i];
        end
    endtask

    task automatic load_chunk_word(input logic [31:0] w);
        chunk[chunk_fill] = w;
        chunk_fill++;
        if (chunk_fill == 16) begin
            compress_chunk();
            chunk_fill = 0;
        end
    endtask

    task automatic absorb_request(input msg_req_t req);
        int          nbytes;
        logic [31:0] keep;
        digest_req_t dig;
        nbytes = (req.count > 4 || !req.last) ? 4 : int'(req.count);
        msg_bits += 64'(nbytes * 8);
        if (!req.last) begin
            load_chunk_word(req.data);
            return;
        end
        if (nbytes == 4) begin
            load_chunk_word(req.data);
            load_chunk_word({PAD_BYTE, 24'h0});
        end else begin
            keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
            load_chunk_word((req.data & keep) | ({24'h0, PAD_BYTE} << (24 - 8 * nbytes)));
        end
        while (chunk_fill != LEN_SLOT) begin
            load_chunk_word(32'h0);
        end
        load_chunk_word(msg_bits[63:32]);
        load_chunk_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) begin
            dig.word  = chain_h[k];
            dig.index = 3'(k);
            dig.last  = (k == 7);
            expected_digests.push_back(dig);
        end
        restart_hash();
    endtask

    task automatic add_request(input logic [31:0] data, input logic [2:0] count,
                               input logic last);
        msg_req_t req;
        req.data  = data;
        req.count = count;
        req.last  = last;
        msg_backlog.push_back(req);
    endtask

    task automatic add_random_message(input int nfull);
        for (int i = 0; i < nfull; i++) begin
            add_request($urandom, ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                        1'b0);
        end
        add_request($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        msg_ch.valid        = 1'b0;
        msg_ch.data_word    = '0;
        msg_ch.byte_count   = '0;
        msg_ch.last_word    = 1'b0;
        dig_ch.ready        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Sender: one request per handshake, predicted as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_ch.valid <= 1'b0;
        end else begin
            if (msg_ch.valid && msg_ch.ready) begin
                absorb_request('{msg_ch.data_word, msg_ch.byte_count, msg_ch.last_word});
                accepted_items++;
            end
            if (!(msg_ch.valid && !msg_ch.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    msg_ch.valid <= 1'b0;
                end else if (msg_backlog.size() > 0) begin
                    msg_req_t req;
                    req = msg_backlog.pop_front();
                    msg_ch.valid      <= 1'b1;
                    msg_ch.data_word  <= req.data;
                    msg_ch.byte_count <= req.count;
                    msg_ch.last_word  <= req.last;
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else if ($urandom_range(0, 99) < 3) begin
                        send_burst = $urandom_range(30, 100);
                        send_gap   = 0;
                    end else begin
                        send_gap = pick_gap();
                    end
                end else begin
                    msg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off once traffic is flowing.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dig_ch.ready <= 1'b0;
        end else begin
            if (dig_ch.valid && dig_ch.ready) begin
                digests_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                dig_ch.ready <= 1'b0;
            end else if (!long_hold_done && digests_seen >= HOLD_TRIGGER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                dig_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                dig_ch.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                dig_ch.ready <= 1'b1;
            end else begin
                int unsigned r;
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    calm_left = $urandom_range(50, 200);
                    dig_ch.ready <= 1'b1;
                end else if (r < 70) begin
                    dig_ch.ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    dig_ch.ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(15, 50);
                    dig_ch.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && dig_ch.valid && dig_ch.ready) begin
            if (expected_digests.size() == 0) begin
                $display("%0t: unexpected digest request word=%h index=%0d last=%b", $time,
                         dig_ch.digest_word, dig_ch.digest_index, dig_ch.digest_last);
                fail_count++;
            end else begin
                digest_req_t exp_dig;
                exp_dig = expected_digests.pop_front();
                if (dig_ch.digest_word !== exp_dig.word
                        || dig_ch.digest_index !== exp_dig.index
                        || dig_ch.digest_last !== exp_dig.last) begin
                    $display("%0t: digest mismatch expected word=%h index=%0d last=%b",
                             $time, exp_dig.word, exp_dig.index, exp_dig.last);
                    $display("%0t:                 actual   word=%h index=%0d last=%b",
                             $time, dig_ch.digest_word, dig_ch.digest_index,
                             dig_ch.digest_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned nfull;
        restart_hash();

        // Empty message, a full last word and partial last words; the invalid bytes of the last word must be dropped.
        add_request(32'hFFFF_FFFF, 3'd0, 1'b1);
        add_request(32'hFFFF_FFFF, 3'd4, 1'b1);
        add_request(32'hFFFF_FFFF, 3'd1, 1'b1);
        add_request(32'h0000_0000, 3'd2, 1'b1);
        add_request(32'hFFFF_FFFF, 3'd3, 1'b1);
        // Counts above four saturate.
        add_request(32'h8A5C_3E71, 3'd5, 1'b1);
        add_request(32'h1234_5678, 3'd7, 1'b1);
        // Partial counts on words that are not last are ignored.
        add_request(32'hFFFF_FFFF, 3'd0, 1'b0);
        add_request(32'h0000_0000, 3'd2, 1'b0);
        add_request(32'hA5A5_5A5A, 3'd6, 1'b0);
        add_request(32'h0000_0000, 3'd4, 1'b1);
        // Padding spills into a second block.
        for (int i = 0; i < 13; i++) begin
            add_request((i % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF, 3'd4, 1'b0);
        end
        add_request(32'hC0FF_EE11, 3'd4, 1'b1);

        r = msg_backlog.size() + RANDOM_ITEMS;
        while (msg_backlog.size() < r) begin
            nfull = $urandom_range(0, 19);
            if (nfull < 14) begin
                add_random_message($urandom_range(0, 20));
            end else if (nfull < 18) begin
                add_random_message($urandom_range(21, 40));
            end else begin
                add_random_message($urandom_range(41, 70));
            end
        end
        total_items = msg_backlog.size();

        do @(posedge i_clk); while (accepted_items != total_items);
        do @(posedge i_clk); while (expected_digests.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sha256_hash_core.f
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_round.sv
src/sha256_hash_core.sv
dv/sha256_hash_core_test.sv
